FILE: rtl/ftqr_pkg.sv
`default_nettype none

package ftqr_pkg;

    localparam int unsigned OP_W     = 2;
    localparam int unsigned TASK_W   = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_FINISH = 2'd1,
        OP_PEEK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/ftqr_if.sv
`default_nettype none

// operation channel
interface ftqr_in_if import ftqr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TASK_W-1:0] task_id;

    modport source (output valid, output operation, output task_id, input ready);
    modport sink   (input valid, input operation, input task_id, output ready);
endinterface

// result channel
interface ftqr_out_if import ftqr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   front_id;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output front_id, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input front_id, input entry_count,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/ftqr_store.sv
`default_nettype none

module ftqr_store #(
    parameter int unsigned DEPTH    = 16,
    parameter int unsigned ID_WIDTH = 16,
    localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic [ID_WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]       i_raddr,
    output logic      [ID_WIDTH-1:0] o_rdata
);

    logic [ID_WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/fifo_task_queue_with_removal_unit.sv
// channel   dir  handshake     payload
// i_in      in   valid/ready   operation[1:0], task_id[15:0]
// o_out     out  valid/ready   status[1:0], front_id[15:0], entry_count[4:0]
//
// add, peek and the unused code: result goes through S_DONE into the output register;
// the next item is accepted only once the unit is back in S_IDLE
// a finish reads and compares the entries one at a time up to the match, then
// moves up the entries behind it, each with a read and a write; this pace is
// set by the single read port of the id store and the one shared id comparator
// reset clears the length, the sequencer and the output valid; the store itself is not cleared
// a result waits in the output register while the next item is accepted;
// the sequencer stalls in its final state only if that register is still full
`default_nettype none

module fifo_task_queue_with_removal_unit import ftqr_pkg::*; #(
    parameter int unsigned DEPTH    = 16,
    parameter int unsigned ID_WIDTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ftqr_in_if.sink    i_in,
    ftqr_out_if.source o_out
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LW = $clog2(DEPTH + 1);

    // sequencer and queue bookkeeping
    t_state              r_state, n_state;
    logic [LW-1:0]       r_len, n_len;       // entries queued
    logic [LW-1:0]       r_idx, n_idx;       // scan / shift position
    logic [ID_WIDTH-1:0] r_id, n_id;         // id being searched for
    logic [ID_WIDTH-1:0] r_front, n_front;   // copy of the front entry
    t_status             r_status, n_status;

    // output register
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [TASK_W-1:0]   r_out_front, n_out_front;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    // store port
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ID_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [ID_WIDTH-1:0] mem_rdata;

    logic                in_fire;
    logic                out_free;
    logic                full;
    logic                id_match;          // the shared comparator
    logic                idx_last;          // r_idx is the last queued entry
    logic [LW-1:0]       idx_inc;
    logic [ID_WIDTH-1:0] in_id;
    t_op                 in_op;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign full     = (r_len >= LW'(DEPTH));
    assign in_id    = ID_WIDTH'(i_in.task_id);
    assign in_op    = t_op'(i_in.operation);
    assign id_match = (mem_rdata == r_id);
    assign idx_inc  = LW'(r_idx + 1'b1);
    assign idx_last = (idx_inc >= r_len);

    assign i_in.ready = (r_state == S_IDLE);

    ftqr_store #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (in_op == OP_FINISH && r_len != '0) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                priority if (id_match) begin
                    n_state = S_SHIFT_RD;
                end else if (idx_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: n_state = idx_last ? S_DONE : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_len        = r_len;
        n_idx        = r_idx;
        n_id         = r_id;
        n_front      = r_front;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_front  = r_out_front;
        n_out_count  = r_out_count;
        mem_we       = 1'b0;
        mem_waddr    = r_idx[AW-1:0];
        mem_wdata    = mem_rdata;
        mem_raddr    = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_id     = in_id;
                    n_idx    = '0;
                    n_status = ST_OK;
                    unique case (in_op)
                        OP_ADD: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                // append at the back
                                mem_we    = 1'b1;
                                mem_waddr = r_len[AW-1:0];
                                mem_wdata = in_id;
                                n_len     = LW'(r_len + 1'b1);
                                if (r_len == '0) begin
                                    n_front = in_id;
                                end
                            end
                        end
                        OP_FINISH: begin
                            if (r_len == '0) begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_PEEK: begin
                            if (r_len == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        OP_NONE: n_status = ST_OK;
                        default: n_status = ST_OK;
                    endcase
                end
            end
            S_SCAN_RD: begin
                mem_raddr = r_idx[AW-1:0];
            end
            S_SCAN_CMP: begin
                // first match stays at r_idx and becomes the hole to close
                if (!id_match) begin
                    if (idx_last) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        n_idx = idx_inc;
                    end
                end
            end
            S_SHIFT_RD: begin
                if (idx_last) begin
                    n_len = LW'(r_len - 1'b1);
                end else begin
                    mem_raddr = idx_inc[AW-1:0];
                end
            end
            S_SHIFT_WR: begin
                // move the next entry up by one place
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = mem_rdata;
                if (r_idx == '0) begin
                    n_front = mem_rdata;
                end
                n_idx = idx_inc;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_front  = (r_len == '0) ? '0 : TASK_W'(r_front);
                    n_out_count  = COUNT_W'(r_len);
                end
            end
            default: n_out_valid = r_out_valid;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_id         <= n_id;
        r_front      <= n_front;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_front  <= n_out_front;
        r_out_count  <= n_out_count;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.front_id    = r_out_front;
    assign o_out.entry_count = r_out_count;

endmodule

`default_nettype wire

FILE: rtl/ftqr_check.sv
`default_nettype none

module ftqr_check import ftqr_pkg::*; #(
    parameter int unsigned DEPTH = 16
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [STATUS_W-1:0] i_status,
    input wire logic [TASK_W-1:0]   i_front_id,
    input wire logic [COUNT_W-1:0]  i_entry_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_front_id) && $stable(i_entry_count))
        else $error("result changed while stalled");

    // an empty queue shows no front id
    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_entry_count == '0 |-> i_front_id == '0)
        else $error("front id set on empty queue");

    // empty status only with nothing queued
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |-> i_entry_count == '0)
        else $error("empty status with entries queued");

    // full status only at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_entry_count == COUNT_W'(DEPTH))
        else $error("full status below capacity");

    // no item is taken while the block is working on one
    a_in_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while busy");

endmodule

bind fifo_task_queue_with_removal_unit ftqr_check #(
    .DEPTH (DEPTH)
) u_ftqr_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_front_id    (o_out.front_id),
    .i_entry_count (o_out.entry_count)
);

`default_nettype wire

FILE: dv/ftqr_queue_monitor.sv
`default_nettype none

// watches both channels, keeps its own copy of the id queue and scores
// every result item against the oldest outstanding prediction
module ftqr_queue_monitor import ftqr_pkg::*; #(
    parameter int DEPTH    = 16,
    parameter int ID_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ftqr_in_if        i_op_ch,
    ftqr_out_if       i_rep_ch,
    output int        o_err_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TASK_W-1:0] ID_MASK = TASK_W'((64'd1 << ID_WIDTH) - 64'd1);

    typedef struct packed {
        t_status             status;
        logic [TASK_W-1:0]   front_id;
        logic [COUNT_W-1:0]  entry_count;
    } queue_report_t;

    logic [TASK_W-1:0] held_ids [DEPTH];
    int                held_count;
    queue_report_t     reports_due [$];
    int                err_total;

    initial begin
        held_count  = 0;
        err_total   = 0;
        o_err_count = 0;
        o_pending   = 0;
    end

    // one queue operation applied to the shadow store
    function automatic queue_report_t apply_queue_op(input t_op op,
                                                      input logic [TASK_W-1:0] raw_id);
        queue_report_t     rep;
        logic [TASK_W-1:0] id;
        int                hit;
        id         = raw_id & ID_MASK;
        rep.status = ST_OK;
        case (op)
            OP_ADD: begin
                if (held_count >= DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    held_ids[held_count] = id;
                    held_count++;
                end
            end
            OP_FINISH: begin
                hit = -1;
                for (int k = 0; k < held_count; k++)
                    if (hit < 0 && held_ids[k] == id) hit = k;
                if (hit < 0) begin
                    rep.status = ST_NOT_FOUND;
                end else begin
                    for (int k = hit; k + 1 < held_count; k++)
                        held_ids[k] = held_ids[k + 1];
                    held_count--;
                end
            end
            OP_PEEK: begin
                if (held_count == 0) rep.status = ST_EMPTY;
            end
            default: ;
        endcase
        rep.front_id    = (held_count == 0) ? '0 : held_ids[0];
        rep.entry_count = COUNT_W'(held_count);
        return rep;
    endfunction

    always @(posedge i_clk) begin
        queue_report_t want;
        if (!i_rst_n) begin
            held_count = 0;
            reports_due.delete();
        end else begin
            if (i_rep_ch.valid && i_rep_ch.ready) begin
                if (reports_due.size() == 0) begin
                    err_total++;
                    $display("%0t: unexpected result expected none actual %0d/%h/%0d", $time,
                             i_rep_ch.status, i_rep_ch.front_id, i_rep_ch.entry_count);
                end else begin
                    want = reports_due.pop_front();
                    if (i_rep_ch.status !== want.status) begin
                        err_total++;
                        $display("%0t: status mismatch expected %0d actual %0d", $time,
                                 want.status, i_rep_ch.status);
                    end
                    if (i_rep_ch.front_id !== want.front_id) begin
                        err_total++;
                        $display("%0t: front_id mismatch expected %h actual %h", $time,
                                 want.front_id, i_rep_ch.front_id);
                    end
                    if (i_rep_ch.entry_count !== want.entry_count) begin
                        err_total++;
                        $display("%0t: entry_count mismatch expected %0d actual %0d", $time,
                                 want.entry_count, i_rep_ch.entry_count);
                    end
                end
            end
            if (i_op_ch.valid && i_op_ch.ready)
                reports_due.push_back(apply_queue_op(t_op'(i_op_ch.operation), i_op_ch.task_id));
        end
        o_err_count <= err_total;
        o_pending   <= reports_due.size();
    end

endmodule

`default_nettype wire

FILE: dv/tb_fifo_task_queue_with_removal_unit.sv
`default_nettype none

module tb_fifo_task_queue_with_removal_unit;
    import ftqr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 16;
    localparam int ID_WIDTH   = 16;
    localparam int BURSTS     = 24;
    localparam int BURST_LEN  = 50;
    // tail wait after the drain, longer than the slowest finish with margin
    localparam int TAIL_CYCLES  = 4 * DEPTH + 16;
    localparam int DRAIN_LIMIT  = 20000;
    // receiver freezes once this many results have gone through
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;
    int   err_count;
    int   pending;
    int   results_taken;

    ftqr_in_if  in_if ();
    ftqr_out_if out_if ();

    fifo_task_queue_with_removal_unit #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    ftqr_queue_monitor #(
        .DEPTH    (DEPTH),
        .ID_WIDTH (ID_WIDTH)
    ) u_monitor (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_op_ch     (in_if),
        .i_rep_ch    (out_if),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // 4 ns period
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // every input known from time zero
    initial begin
        rst_n           = 1'b0;
        in_if.valid     = 1'b0;
        in_if.operation = OP_NONE;
        in_if.task_id   = '0;
        out_if.ready    = 1'b0;
    end

    // hard stop well past the slowest legal run
    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    // offer one item after a gap of idle cycles, return once it is taken
    task automatic send_op(input t_op op, input logic [TASK_W-1:0] id, input int gap);
        if (gap > 0) begin
            @(negedge clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.task_id   <= id;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
    endtask

    // hold the sender until the unit has answered everything in flight
    task automatic wait_all_answered();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // receiver side: per-result stall drawn from a mode that changes every
    // 64 results, so there are stretches with no stalls at all
    initial begin
        int stall;
        int mode;
        results_taken = 0;
        mode          = 0;
        @(posedge rst_n);
        forever begin
            if (results_taken % 64 == 0) mode = $urandom_range(0, 2);
            case (mode)
                0:       stall = 0;
                1:       stall = $urandom_range(0, 18);
                default: stall = $urandom_range(0, 3);
            endcase
            // one long freeze so the output register fills and input backs up
            if (results_taken == HOLD_AT) stall = HOLD_CYCLES;
            if (stall > 0) begin
                @(negedge clk);
                out_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
            results_taken++;
        end
    end

    // stimulus
    initial begin
        logic [TASK_W-1:0] id_pool [8];
        logic [TASK_W-1:0] id;
        t_op               op;
        int                add_pct;
        int                gap_mode;
        int                gap;
        int                pick;
        int                item_no;
        int                waited;

        // reset asserted from time zero, released on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        // empty queue: peek, finish, unused code
        send_op(OP_PEEK,   16'h0000, $urandom_range(0, 3));
        send_op(OP_FINISH, 16'h0000, $urandom_range(0, 3));
        send_op(OP_NONE,   16'hFFFF, $urandom_range(0, 3));
        // fill to the top: extreme ids and a duplicate pair near the front
        send_op(OP_ADD,    16'h0000, $urandom_range(0, 3));
        send_op(OP_ADD,    16'hFFFF, $urandom_range(0, 3));
        send_op(OP_ADD,    16'h1234, $urandom_range(0, 3));
        send_op(OP_ADD,    16'h00A5, $urandom_range(0, 3));
        send_op(OP_ADD,    16'h1234, $urandom_range(0, 3));
        for (int k = 0; k < DEPTH - 5; k++)
            send_op(OP_ADD, TASK_W'(16'h0100 + k), $urandom_range(0, 3));
        // add to a full queue is refused
        send_op(OP_ADD,    16'hBEEF, $urandom_range(0, 3));
        // duplicate in the middle: only the first copy goes
        send_op(OP_FINISH, 16'h1234, $urandom_range(0, 3));
        // last entry, then the front entry
        send_op(OP_FINISH, TASK_W'(16'h0100 + DEPTH - 6), $urandom_range(0, 3));
        send_op(OP_FINISH, 16'h0000, $urandom_range(0, 3));
        // id not present
        send_op(OP_FINISH, 16'hDEAD, $urandom_range(0, 3));
        send_op(OP_PEEK,   16'h5A5A, $urandom_range(0, 3));
        send_op(OP_NONE,   16'h0000, $urandom_range(0, 3));
        wait_all_answered();

        // --- random part ---
        // each burst has its own add/finish balance, gap style and a small id
        // pool so finishes mostly hit; stray full-range ids keep every bit busy
        item_no = 0;
        for (int b = 0; b < BURSTS; b++) begin
            add_pct  = $urandom_range(20, 80);
            gap_mode = $urandom_range(0, 2);
            foreach (id_pool[k]) id_pool[k] = TASK_W'($urandom);
            // one burst mid-run pauses first until the unit is quiet
            if (b == BURSTS / 2) wait_all_answered();
            for (int n = 0; n < BURST_LEN; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < add_pct)
                    op = OP_ADD;
                else if (pick < 88)
                    op = OP_FINISH;
                else if (pick < 95)
                    op = OP_PEEK;
                else
                    op = OP_NONE;
                if ($urandom_range(0, 99) < 85)
                    id = id_pool[$urandom_range(0, 7)];
                else
                    id = TASK_W'($urandom);
                case (gap_mode)
                    0:       gap = 0;
                    1:       gap = $urandom_range(0, 18);
                    default: gap = $urandom_range(0, 2);
                endcase
                // keep offering back to back around the receiver freeze
                if (item_no >= HOLD_AT - 20 && item_no < HOLD_AT + 80) gap = 0;
                send_op(op, id, gap);
                item_no++;
            end
        end

        // drain, then let any late result show up
        @(negedge clk);
        in_if.valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
